// File: hw/rtl/urs_pkg.sv
package urs_pkg;

    localparam int TICK_BITS   = 16;
    localparam int DELAY_W     = 8;
    localparam int DIST_W      = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int IN_USER_W   = 1;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;

    // Millimeters per two ticks of echo time (ticks * 85 / 2).
    localparam int MM_PER_2TICKS = 85;
    localparam int MM_MULT_W     = 7;

    localparam logic [DELAY_W-1:0] LISTEN_DELAY_RST = DELAY_W'(6);
    localparam logic [DELAY_W-1:0] TIMEOUT_RST      = DELAY_W'(160);
    localparam logic [DIST_W-1:0]  MIN_DIST_RST     = DIST_W'(250);
    localparam logic [DIST_W-1:0]  MAX_DIST_RST     = DIST_W'(2550);
    localparam logic [DIST_W-1:0]  NO_ECHO_RST      = DIST_W'(160);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LISTEN_DELAY = 3'd0,
        CFG_TIMEOUT      = 3'd1,
        CFG_MIN_DIST     = 3'd2,
        CFG_MAX_DIST     = 3'd3,
        CFG_NO_ECHO      = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        BEEP_NONE  = 2'd0,
        BEEP_SHORT = 2'd1,
        BEEP_LONG  = 2'd2
    } t_beep;

    typedef struct packed {
        logic [DIST_W-1:0]  no_echo;
        logic [DIST_W-1:0]  max_dist;
        logic [DIST_W-1:0]  min_dist;
        logic [DELAY_W-1:0] timeout;
        logic [DELAY_W-1:0] listen_delay;
    } t_cfg;

    typedef struct packed {
        logic              measure_mode;
        logic [DIST_W-1:0] distance_mm;
        logic              obstacle_present;
        logic              sensor_ok;
        t_beep             beep_kind;
        logic              disarm_receiver;
        logic              arm_receiver;
        logic              fire_pulse;
        logic              measuring;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// File: hw/rtl/urs_cfg.sv
module urs_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [urs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [urs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output urs_pkg::t_cfg                  o_cfg
);
    import urs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_delay <= LISTEN_DELAY_RST;
            r_cfg.timeout      <= TIMEOUT_RST;
            r_cfg.min_dist     <= MIN_DIST_RST;
            r_cfg.max_dist     <= MAX_DIST_RST;
            r_cfg.no_echo      <= NO_ECHO_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LISTEN_DELAY: r_cfg.listen_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_TIMEOUT:      r_cfg.timeout      <= i_cfg_data[DELAY_W-1:0];
                CFG_MIN_DIST:     r_cfg.min_dist     <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DIST:     r_cfg.max_dist     <= i_cfg_data[DIST_W-1:0];
                CFG_NO_ECHO:      r_cfg.no_echo      <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/urs_convert.sv
module urs_convert (
    input  logic [urs_pkg::TICK_BITS-1:0] i_elapsed,
    input  logic [urs_pkg::DIST_W-1:0]    i_min_dist,
    input  logic [urs_pkg::DIST_W-1:0]    i_max_dist,
    output logic [urs_pkg::DIST_W-1:0]    o_distance_mm
);
    import urs_pkg::*;

    localparam int PROD_W = TICK_BITS + MM_MULT_W;
    localparam int MM_W   = PROD_W - 1;

    logic [PROD_W-1:0] prod;
    logic [MM_W-1:0]   mm_full;
    logic [MM_W-1:0]   min_ext;
    logic [MM_W-1:0]   max_ext;

    assign prod    = {{MM_MULT_W{1'b0}}, i_elapsed} * PROD_W'(MM_PER_2TICKS);
    assign mm_full = prod[PROD_W-1:1];
    assign min_ext = {{(MM_W-DIST_W){1'b0}}, i_min_dist};
    assign max_ext = {{(MM_W-DIST_W){1'b0}}, i_max_dist};

    // The minimum test takes priority, so bounds in the wrong order give zero first.
    always_comb begin
        if (mm_full < min_ext) begin
            o_distance_mm = '0;
        end else if (mm_full > max_ext) begin
            o_distance_mm = i_max_dist;
        end else begin
            o_distance_mm = mm_full[DIST_W-1:0];
        end
    end

endmodule

// File: hw/rtl/ultrasonic_ranging_sequencer.sv
// Pipeline: an accepted item is held in the input register and its result moves to the
// result register, which drives the master side, once that register is free or drained.
// Throughput: one item per cycle from the register pair, unless master back-pressure stalls it.
// Reset: synchronous, active low; clears the sequencer state, both stage valids and
// restores the default register values.
module ultrasonic_ranging_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: tick_now[15:0], serial_busy[16], pulse_sending[17], echo_waiting[18].
    input  logic [urs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: operation[0].
    input  logic [urs_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: measuring[0], fire_pulse[1], arm_receiver[2], disarm_receiver[3],
    // beep_kind[5:4], sensor_ok[6], obstacle_present[7], distance_mm[19:8],
    // measure_mode[20].
    output logic [urs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [urs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [urs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import urs_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRE    = 2'd0,
        PH_BURST   = 2'd1,
        PH_CHECK   = 2'd2,
        PH_MEASURE = 2'd3
    } t_phase;

    t_cfg cfg;

    logic                 r_in_valid;
    logic                 r_in_start;
    logic [TICK_BITS-1:0] r_in_tick;
    logic                 r_in_busy;
    logic                 r_in_sending;
    logic                 r_in_echo;

    logic    r_out_valid;
    t_result r_out;

    logic                 r_active;
    t_phase               r_phase;
    logic                 r_mode;
    logic [TICK_BITS-1:0] r_stamp;
    logic [DIST_W-1:0]    r_dist;
    logic                 r_ok;
    logic                 r_obst;

    logic                 n_active;
    t_phase               n_phase;
    logic                 n_mode;
    logic [TICK_BITS-1:0] n_stamp;
    logic [DIST_W-1:0]    n_dist;
    logic                 n_ok;
    logic                 n_obst;
    t_result              n_out;

    logic                 advance;
    logic                 in_accept;
    logic [TICK_BITS-1:0] elapsed;
    logic                 delay_done;
    logic                 timed_out;
    logic [DIST_W-1:0]    echo_mm;
    logic                 fire;
    logic                 arm;
    logic                 disarm;
    t_beep                beep;

    urs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign elapsed    = r_in_tick - r_stamp;
    assign delay_done = elapsed >= {{(TICK_BITS-DELAY_W){1'b0}}, cfg.listen_delay};
    assign timed_out  = elapsed >= {{(TICK_BITS-DELAY_W){1'b0}}, cfg.timeout};

    urs_convert u_convert (
        .i_elapsed     (elapsed),
        .i_min_dist    (cfg.min_dist),
        .i_max_dist    (cfg.max_dist),
        .o_distance_mm (echo_mm)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_active = r_active;
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_stamp  = r_stamp;
        n_dist   = r_dist;
        n_ok     = r_ok;
        n_obst   = r_obst;
        fire     = 1'b0;
        arm      = 1'b0;
        disarm   = 1'b0;
        beep     = BEEP_NONE;
        if (r_in_start) begin
            n_active = 1'b1;
            n_phase  = PH_FIRE;
        end else if (r_active) begin
            unique case (r_phase)
                PH_FIRE: begin
                    if (!r_in_busy) begin
                        n_stamp = r_in_tick;
                        fire    = 1'b1;
                        n_dist  = '0;
                        n_phase = PH_BURST;
                    end
                end
                PH_BURST: begin
                    if (!r_in_sending) begin
                        if (!r_mode) begin
                            arm     = 1'b1;
                            n_phase = PH_CHECK;
                        end else if (delay_done) begin
                            arm     = 1'b1;
                            n_phase = PH_MEASURE;
                        end
                    end
                end
                PH_CHECK: begin
                    if (!r_in_echo) begin
                        n_mode   = 1'b1;
                        n_ok     = 1'b1;
                        beep     = BEEP_SHORT;
                        n_active = 1'b0;
                    end else if (timed_out) begin
                        n_ok     = 1'b0;
                        beep     = BEEP_LONG;
                        n_active = 1'b0;
                        disarm   = 1'b1;
                    end
                end
                PH_MEASURE: begin
                    if (!r_in_echo) begin
                        n_dist   = echo_mm;
                        n_obst   = 1'b1;
                        n_active = 1'b0;
                    end else if (timed_out) begin
                        n_obst   = 1'b0;
                        n_active = 1'b0;
                        n_dist   = cfg.no_echo;
                        disarm   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        n_out.measuring        = n_active;
        n_out.fire_pulse       = fire;
        n_out.arm_receiver     = arm;
        n_out.disarm_receiver  = disarm;
        n_out.beep_kind        = beep;
        n_out.sensor_ok        = n_ok;
        n_out.obstacle_present = n_obst;
        n_out.distance_mm      = n_dist;
        n_out.measure_mode     = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_phase     <= PH_FIRE;
            r_mode      <= 1'b0;
            r_stamp     <= '0;
            r_dist      <= '0;
            r_ok        <= 1'b0;
            r_obst      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_active    <= n_active;
                r_phase     <= n_phase;
                r_mode      <= n_mode;
                r_stamp     <= n_stamp;
                r_dist      <= n_dist;
                r_ok        <= n_ok;
                r_obst      <= n_obst;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_accept) begin
            r_in_start   <= s_axis_tuser[0];
            r_in_tick    <= s_axis_tdata[TICK_BITS-1:0];
            r_in_busy    <= s_axis_tdata[TICK_BITS];
            r_in_sending <= s_axis_tdata[TICK_BITS+1];
            r_in_echo    <= s_axis_tdata[TICK_BITS+2];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, r_out};

    a_fire_clears_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fire_pulse) |-> (r_out.distance_mm == '0 && r_out.measuring))
        else $error("fire result must clear distance and keep the cycle active");

    a_beep_ends_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.beep_kind != BEEP_NONE) |-> !r_out.measuring)
        else $error("self-check beep must end the cycle");

    a_disarm_no_obst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.disarm_receiver) |-> (!r_out.measuring && !r_out.arm_receiver))
        else $error("timeout must end the cycle without arming");

    a_mode_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_mode) |-> r_mode)
        else $error("measure mode must stay set until reset");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input may stall only with both stages full");

endmodule

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import urs_pkg::*;

    localparam int unsigned MM_PER_TWO_TICKS = 85;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned STALL_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS_PER_PHASE = 50;
    localparam int unsigned MAX_POLLS_PER_CYCLE = 80;

    typedef enum logic [1:0] {
        PH_FIRE,
        PH_BURST,
        PH_SELF_CHECK,
        PH_MEASURE
    } t_range_phase;

    typedef struct packed {
        logic                 start;
        logic [TICK_BITS-1:0] tick;
        logic                 serial_busy;
        logic                 pulse_sending;
        logic                 echo_waiting;
    } t_poll;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    ultrasonic_ranging_sequencer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_cfg rng_cfg = '{no_echo: NO_ECHO_RST, max_dist: MAX_DIST_RST, min_dist: MIN_DIST_RST,
                      timeout: TIMEOUT_RST, listen_delay: LISTEN_DELAY_RST};
    logic                 rng_active = 1'b0;
    t_range_phase         rng_phase = PH_FIRE;
    logic                 rng_measure_mode = 1'b0;
    logic [TICK_BITS-1:0] rng_fire_stamp = '0;
    logic [DIST_W-1:0]    rng_distance = '0;
    logic                 rng_sensor_ok = 1'b0;
    logic                 rng_obstacle = 1'b0;

    t_result     expected_results[$];
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned tx_idle_pct = 32;
    int unsigned rx_idle_pct = 61;
    logic [TICK_BITS-1:0] ranging_tick = '0;
    logic        stall_request = 1'b0;
    int unsigned stall_left = 0;

    function automatic logic [DIST_W-1:0] echo_to_mm(input logic [TICK_BITS-1:0] ticks);
        logic [31:0] mm;
        mm = (32'(ticks) * MM_PER_TWO_TICKS) >> 1;
        if (mm < 32'(rng_cfg.min_dist)) return '0;
        if (mm > 32'(rng_cfg.max_dist)) return rng_cfg.max_dist;
        return mm[DIST_W-1:0];
    endfunction

    // Advances the sequencer copy by one item and returns the result it shows.
    function automatic t_result ranging_step(input t_poll p);
        t_result r;
        logic [TICK_BITS-1:0] elapsed;
        r = '0;
        elapsed = p.tick - rng_fire_stamp;
        if (p.start) begin
            rng_active = 1'b1;
            rng_phase = PH_FIRE;
        end else if (rng_active) begin
            case (rng_phase)
                PH_FIRE: begin
                    if (!p.serial_busy) begin
                        rng_fire_stamp = p.tick;
                        r.fire_pulse = 1'b1;
                        rng_distance = '0;
                        rng_phase = PH_BURST;
                    end
                end
                PH_BURST: begin
                    if (!p.pulse_sending) begin
                        if (!rng_measure_mode) begin
                            r.arm_receiver = 1'b1;
                            rng_phase = PH_SELF_CHECK;
                        end else if (elapsed >= rng_cfg.listen_delay) begin
                            r.arm_receiver = 1'b1;
                            rng_phase = PH_MEASURE;
                        end
                    end
                end
                PH_SELF_CHECK: begin
                    if (!p.echo_waiting) begin
                        rng_measure_mode = 1'b1;
                        rng_sensor_ok = 1'b1;
                        r.beep_kind = BEEP_SHORT;
                        rng_active = 1'b0;
                    end else if (elapsed >= rng_cfg.timeout) begin
                        rng_sensor_ok = 1'b0;
                        r.beep_kind = BEEP_LONG;
                        r.disarm_receiver = 1'b1;
                        rng_active = 1'b0;
                    end
                end
                default: begin
                    if (!p.echo_waiting) begin
                        rng_distance = echo_to_mm(elapsed);
                        rng_obstacle = 1'b1;
                        rng_active = 1'b0;
                    end else if (elapsed >= rng_cfg.timeout) begin
                        rng_distance = rng_cfg.no_echo;
                        rng_obstacle = 1'b0;
                        r.disarm_receiver = 1'b1;
                        rng_active = 1'b0;
                    end
                end
            endcase
        end
        r.measuring = rng_active;
        r.sensor_ok = rng_sensor_ok;
        r.obstacle_present = rng_obstacle;
        r.distance_mm = rng_distance;
        r.measure_mode = rng_measure_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH at result %0d: %s is %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RESULT_W-1:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                check_field("measuring", got.measuring, want.measuring);
                check_field("fire_pulse", got.fire_pulse, want.fire_pulse);
                check_field("arm_receiver", got.arm_receiver, want.arm_receiver);
                check_field("disarm_receiver", got.disarm_receiver, want.disarm_receiver);
                check_field("beep_kind", got.beep_kind, want.beep_kind);
                check_field("sensor_ok", got.sensor_ok, want.sensor_ok);
                check_field("obstacle_present", got.obstacle_present, want.obstacle_present);
                check_field("distance_mm", got.distance_mm, want.distance_mm);
                check_field("measure_mode", got.measure_mode, want.measure_mode);
            end
            results_seen++;
        end
    end

    // The receiver idles at random, or holds off for a long stretch on request.
    always @(posedge i_clk) begin
        if (stall_request) begin
            stall_left <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input t_poll p);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= p.start;
        s_axis_tdata <= {{(IN_DATA_W-19){1'b0}}, p.echo_waiting, p.pulse_sending,
                         p.serial_busy, p.tick};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(ranging_step(p));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_registers(input t_cfg c);
        t_cfg_index order[5] = '{CFG_LISTEN_DELAY, CFG_TIMEOUT, CFG_MIN_DIST,
                                 CFG_MAX_DIST, CFG_NO_ECHO};
        logic [CFG_DATA_W-1:0] value[5];
        value = '{CFG_DATA_W'(c.listen_delay), CFG_DATA_W'(c.timeout), c.min_dist,
                  c.max_dist, c.no_echo};
        foreach (order[k]) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data <= value[k];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        rng_cfg = c;
    endtask

    function automatic t_poll random_poll();
        t_poll p;
        p.start = 1'($urandom_range(0, 1));
        p.tick = TICK_BITS'($urandom);
        p.serial_busy = 1'($urandom_range(0, 1));
        p.pulse_sending = 1'($urandom_range(0, 1));
        p.echo_waiting = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic drive_poll(input logic start, input logic [TICK_BITS-1:0] tick,
                              input logic busy, input logic sending, input logic waiting);
        send_item('{start: start, tick: tick, serial_busy: busy, pulse_sending: sending,
                    echo_waiting: waiting});
    endtask

    // One ranging cycle from a start request, with a little noise mixed in.
    task automatic run_ranging_cycle();
        t_poll p;
        int unsigned max_step;
        int unsigned echo_odds;
        int unsigned polls;
        max_step = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
        echo_odds = $urandom_range(1, 30);
        ranging_tick = TICK_BITS'($urandom);
        p = random_poll();
        p.start = 1'b1;
        send_item(p);
        polls = 0;
        while (rng_active && polls < MAX_POLLS_PER_CYCLE) begin
            p = random_poll();
            if ($urandom_range(0, 24) != 0) begin
                ranging_tick += TICK_BITS'($urandom_range(0, max_step));
                if ($urandom_range(0, 63) == 0) ranging_tick = TICK_BITS'($urandom);
                p.start = 1'b0;
                p.tick = ranging_tick;
                p.serial_busy = ($urandom_range(0, 3) == 0);
                p.pulse_sending = ($urandom_range(0, 2) == 0);
                p.echo_waiting = ($urandom_range(1, echo_odds) != 1);
            end
            send_item(p);
            polls++;
        end
        repeat ($urandom_range(0, 2)) begin
            p = random_poll();
            p.start = 1'b0;
            send_item(p);
        end
    endtask

    task automatic test_directed_sequence();
        drive_poll(1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        drive_poll(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b1, 16'h1234, 1'b1, 1'b1, 1'b1);
        drive_poll(1'b0, 16'h0000, 1'b1, 1'b0, 1'b0);
        drive_poll(1'b0, 16'hFFF0, 1'b0, 1'b1, 1'b1);
        drive_poll(1'b0, 16'hFFF1, 1'b0, 1'b1, 1'b1);
        drive_poll(1'b0, 16'hFFF2, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'h008F, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'h0090, 1'b1, 1'b1, 1'b1);
        drive_poll(1'b1, 16'd100, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b0, 16'd100, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b0, 16'd101, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b0, 16'd102, 1'b1, 1'b1, 1'b0);
        drive_poll(1'b1, 16'd200, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b0, 16'h8000, 1'b0, 1'b1, 1'b1);
        drive_poll(1'b0, 16'h8005, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'h8006, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'h803C, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b0, 16'd1000, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'd1006, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'd999, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
        drive_poll(1'b0, 16'd2000, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'd2010, 1'b0, 1'b0, 1'b1);
        drive_poll(1'b0, 16'd2160, 1'b0, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_register_corners();
        t_cfg settings[4];
        settings[0] = '{no_echo: 12'd2550, max_dist: 12'd2550, min_dist: 12'd0,
                        timeout: 8'd0, listen_delay: 8'd0};
        settings[1] = '{no_echo: 12'd0, max_dist: 12'd0, min_dist: 12'd2550,
                        timeout: 8'd255, listen_delay: 8'd255};
        settings[2] = '{no_echo: 12'd1023, max_dist: 12'd1200, min_dist: 12'd400,
                        timeout: 8'd40, listen_delay: 8'd1};
        settings[3] = '{no_echo: NO_ECHO_RST, max_dist: MAX_DIST_RST, min_dist: MIN_DIST_RST,
                        timeout: TIMEOUT_RST, listen_delay: LISTEN_DELAY_RST};
        foreach (settings[k]) begin
            load_registers(settings[k]);
            repeat (3) run_ranging_cycle();
            wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        int unsigned target;
        for (int phase_n = 0; phase_n < 3; phase_n++) begin
            case (phase_n)
                0: begin
                    tx_idle_pct = 32;
                    rx_idle_pct = 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct = 32;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            c.listen_delay = ($urandom_range(0, 3) == 0) ? DELAY_W'($urandom_range(0, 255))
                                                         : DELAY_W'($urandom_range(0, 12));
            c.timeout = DELAY_W'($urandom_range(0, 255));
            c.min_dist = DIST_W'($urandom_range(0, 1200));
            c.max_dist = DIST_W'($urandom_range(0, 2550));
            c.no_echo = DIST_W'($urandom_range(0, 2550));
            load_registers(c);
            target = items_sent + RANDOM_ITEMS_PER_PHASE;
            while (items_sent < target) run_ranging_cycle();
            wait_drained();
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_request <= 1'b1;
        @(posedge i_clk);
        stall_request <= 1'b0;
        repeat (2) run_ranging_cycle();
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sequence();
        test_register_corners();
        test_random_traffic();
        test_output_backpressure();
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", expected_results.size(), 0);
        $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
        $display("Covered self-check, echo and timeout paths, register corners and stalls.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout after %0d items and %0d results.", items_sent, results_seen);
        $display("Some tests failed");
        $finish;
    end

endmodule
